// ----- rtl/core/ccx_pkg.sv -----
// ccx_pkg: shared constants and types for the ChaCha20 stream XOR block.
// Used by the front, keystream engine, back and top level modules.
package ccx_pkg;
    localparam int unsigned AddrW = 6;
    localparam logic [AddrW-1:0] RegKey0   = 6'h00;
    localparam logic [AddrW-1:0] RegKey1   = 6'h08;
    localparam logic [AddrW-1:0] RegKey2   = 6'h10;
    localparam logic [AddrW-1:0] RegKey3   = 6'h18;
    localparam logic [AddrW-1:0] RegNonceL = 6'h20;
    localparam logic [AddrW-1:0] RegNonceH = 6'h28;

    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;

    localparam int unsigned DoubleRounds = 10;
    localparam int unsigned QueueDepth = 4;

    typedef logic [15:0][31:0] t_block;

    // one queued byte request
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [5:0] pos;
    } t_req;

    // key material captured with a block request
    typedef struct packed {
        logic [255:0] key;
        logic [95:0]  nonce;
        logic [31:0]  counter;
    } t_seed;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // one quarter round on four words
    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qround = {td, tc, tb, ta};
    endfunction
endpackage

// ----- rtl/core/ccx_core.sv -----
// ccx_core: iterative ChaCha20 block function, one half double round per cycle.
// Depends on ccx_pkg for the constants and quarter round.
module ccx_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ccx_pkg::t_seed  i_seed,
    output logic            o_busy,
    output logic            o_done,
    output ccx_pkg::t_block o_block
);
    import ccx_pkg::*;

    t_block r_init, r_work, n_work, r_out;
    logic [4:0] r_step;
    logic r_busy, r_done;
    logic [127:0] q0, q1, q2, q3;

    // column rounds on even steps, diagonal rounds on odd steps
    always_comb begin
        n_work = r_work;
        if (!r_step[0]) begin
            q0 = qround(r_work[0], r_work[4], r_work[8],  r_work[12]);
            q1 = qround(r_work[1], r_work[5], r_work[9],  r_work[13]);
            q2 = qround(r_work[2], r_work[6], r_work[10], r_work[14]);
            q3 = qround(r_work[3], r_work[7], r_work[11], r_work[15]);
            {n_work[12], n_work[8],  n_work[4], n_work[0]} = q0;
            {n_work[13], n_work[9],  n_work[5], n_work[1]} = q1;
            {n_work[14], n_work[10], n_work[6], n_work[2]} = q2;
            {n_work[15], n_work[11], n_work[7], n_work[3]} = q3;
        end else begin
            q0 = qround(r_work[0], r_work[5], r_work[10], r_work[15]);
            q1 = qround(r_work[1], r_work[6], r_work[11], r_work[12]);
            q2 = qround(r_work[2], r_work[7], r_work[8],  r_work[13]);
            q3 = qround(r_work[3], r_work[4], r_work[9],  r_work[14]);
            {n_work[15], n_work[10], n_work[5], n_work[0]} = q0;
            {n_work[12], n_work[11], n_work[6], n_work[1]} = q1;
            {n_work[13], n_work[8],  n_work[7], n_work[2]} = q2;
            {n_work[14], n_work[9],  n_work[4], n_work[3]} = q3;
        end
    end

    // load state, iterate twenty half rounds, add the input state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start && !r_busy) begin
            r_init <= {i_seed.nonce[95:64], i_seed.nonce[63:32], i_seed.nonce[31:0],
                       i_seed.counter, i_seed.key[255:224], i_seed.key[223:192],
                       i_seed.key[191:160], i_seed.key[159:128], i_seed.key[127:96],
                       i_seed.key[95:64], i_seed.key[63:32], i_seed.key[31:0],
                       Sigma3, Sigma2, Sigma1, Sigma0};
            r_work <= {i_seed.nonce[95:64], i_seed.nonce[63:32], i_seed.nonce[31:0],
                       i_seed.counter, i_seed.key[255:224], i_seed.key[223:192],
                       i_seed.key[191:160], i_seed.key[159:128], i_seed.key[127:96],
                       i_seed.key[95:64], i_seed.key[63:32], i_seed.key[31:0],
                       Sigma3, Sigma2, Sigma1, Sigma0};
            r_step <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_step <= r_step + 5'd1;
            r_done <= (r_step == 5'(2 * DoubleRounds - 1));
            if (r_step == 5'(2 * DoubleRounds - 1)) begin
                r_busy <= 1'b0;
                for (int i = 0; i < 16; i++) r_out[i] <= n_work[i] + r_init[i];
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_block = r_out;
endmodule

// ----- rtl/core/ccx_front.sv -----
// ccx_front: accepts bytes, tracks position and counter, requests new blocks.
// Depends on ccx_pkg; feeds the byte queue and the block engine.
module ccx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data,
    input  logic           i_last,
    input  logic [255:0]   i_key,
    input  logic [95:0]    i_nonce,
    input  logic           i_q_full,
    input  logic           i_blk_free,
    output logic           o_push,
    output ccx_pkg::t_req  o_req,
    output logic           o_blk_req,
    output ccx_pkg::t_seed o_seed
);
    import ccx_pkg::*;

    logic [5:0]  r_pos;
    logic [31:0] r_ctr;
    logic        need_blk, acc;

    // a byte at position zero needs a free block slot
    assign need_blk  = (r_pos == 6'd0);
    assign o_ready   = !i_q_full && (!need_blk || i_blk_free);
    assign acc       = i_valid && o_ready;
    assign o_push    = acc;
    assign o_req     = '{data: i_data, last: i_last, pos: r_pos};
    assign o_blk_req = acc && need_blk;
    assign o_seed    = '{key: i_key, nonce: i_nonce, counter: r_ctr};

    // advance position, count blocks, clear on last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ctr <= '0;
        end else if (acc) begin
            if (i_last) begin
                r_pos <= '0;
                r_ctr <= '0;
            end else begin
                r_pos <= r_pos + 6'd1;
                if (need_blk) r_ctr <= r_ctr + 32'd1;
            end
        end
    end
endmodule

// ----- rtl/core/ccx_back.sv -----
// ccx_back: byte queue, two keystream block slots and the output register.
// Depends on ccx_pkg and ccx_core.
module ccx_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccx_pkg::t_req  i_req,
    input  logic           i_blk_req,
    input  ccx_pkg::t_seed i_seed,
    output logic           o_q_full,
    output logic           o_blk_free,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data,
    output logic           o_last
);
    import ccx_pkg::*;

    localparam int unsigned QW = $clog2(QueueDepth);

    t_req r_q [QueueDepth];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    logic pop;

    // seed queue for blocks waiting on the engine, block slots ready to read
    t_seed r_sq [2];
    logic r_sv [2];
    logic r_sw, r_sr;
    t_block r_blk [2];
    logic r_bv [2];
    logic r_bw, r_br;
    logic [1:0] r_bcnt;

    logic core_busy, core_done;
    t_block core_blk;
    logic start;
    t_req head;
    t_block cur;
    logic [31:0] word;
    logic [7:0] ks;
    logic r_ov;
    logic [7:0] r_od;
    logic r_ol;

    assign start = r_sv[r_sr] && !core_busy && !core_done;

    ccx_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_seed(r_sq[r_sr]),
        .o_busy(core_busy), .o_done(core_done), .o_block(core_blk)
    );

    assign head = r_q[r_rp];
    assign cur  = r_blk[r_br];
    assign word = cur[head.pos[5:2]];
    assign ks   = word[{head.pos[1:0], 3'b000} +: 8];
    assign pop  = (r_cnt != '0) && r_bv[r_br] && (!r_ov || i_ready);
    assign o_q_full   = (r_cnt == (QW+1)'(QueueDepth));
    assign o_blk_free = (r_bcnt != 2'd2);

    // queue and block bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
            r_sv[0] <= 1'b0; r_sv[1] <= 1'b0; r_sw <= 1'b0; r_sr <= 1'b0;
            r_bv[0] <= 1'b0; r_bv[1] <= 1'b0; r_bw <= 1'b0; r_br <= 1'b0;
            r_bcnt <= '0; r_ov <= 1'b0;
        end else begin
            if (i_push) begin
                r_q[r_wp] <= i_req;
                r_wp <= r_wp + 1'b1;
            end
            r_cnt <= r_cnt + (QW+1)'(i_push) - (QW+1)'(pop);
            if (i_blk_req) begin
                r_sq[r_sw] <= i_seed;
                r_sv[r_sw] <= 1'b1;
                r_sw <= !r_sw;
            end
            if (start) begin
                r_sv[r_sr] <= 1'b0;
                r_sr <= !r_sr;
            end
            if (core_done) begin
                r_blk[r_bw] <= core_blk;
                r_bv[r_bw] <= 1'b1;
                r_bw <= !r_bw;
            end
            // release the slot after its final byte
            if (pop && (head.last || head.pos == 6'd63)) begin
                r_bv[r_br] <= 1'b0;
                r_br <= !r_br;
            end
            r_bcnt <= r_bcnt + 2'(i_blk_req)
                      - 2'(pop && (head.last || head.pos == 6'd63));
            if (pop) begin
                r_rp <= r_rp + 1'b1;
                r_ov <= 1'b1;
                r_od <= head.data ^ ks;
                r_ol <= head.last;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_last  = r_ol;
endmodule

// ----- rtl/core/chacha20_stream_xor.sv -----
// chacha20_stream_xor: ChaCha20 byte stream XOR with APB key and nonce setup.
// Each accepted byte goes through the byte queue into the output register; the first
// byte of a block waits in the queue until the engine has made its keystream block.
// Throughput: 1 byte per cycle in a block unless the output stalls; blocks are made on
// demand, one at a time, so a block start stalls the input once the queue is full.
// Reset: synchronous active low i_rst_n clears position, counter, queues and regs.
module chacha20_stream_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] result_byte
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ccx_pkg::*;

    logic [63:0] r_k0, r_k1, r_k2, r_k3, r_nl;
    logic [31:0] r_nh;
    logic wr, q_full, blk_free, push, blk_req;
    t_req req;
    t_seed seed;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0; r_k1 <= '0; r_k2 <= '0; r_k3 <= '0; r_nl <= '0; r_nh <= '0;
        end else if (wr) begin
            unique case (paddr)
                RegKey0:   r_k0 <= pwdata;
                RegKey1:   r_k1 <= pwdata;
                RegKey2:   r_k2 <= pwdata;
                RegKey3:   r_k3 <= pwdata;
                RegNonceL: r_nl <= pwdata;
                RegNonceH: r_nh <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr)
            RegKey0:   prdata = r_k0;
            RegKey1:   prdata = r_k1;
            RegKey2:   prdata = r_k2;
            RegKey3:   prdata = r_k3;
            RegNonceL: prdata = r_nl;
            RegNonceH: prdata = {32'd0, r_nh};
            default:   prdata = '0;
        endcase
    end

    ccx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_last(s_axis_tlast), .i_key({r_k3, r_k2, r_k1, r_k0}),
        .i_nonce({r_nh, r_nl}), .i_q_full(q_full), .i_blk_free(blk_free),
        .o_push(push), .o_req(req), .o_blk_req(blk_req), .o_seed(seed)
    );

    ccx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(req),
        .i_blk_req(blk_req), .i_seed(seed), .o_q_full(q_full), .o_blk_free(blk_free),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata),
        .o_last(m_axis_tlast)
    );
endmodule

// ----- tb/chacha20_stream_xor_tb.sv -----
// chacha20_stream_xor_tb: self-checking bench for the ChaCha20 byte stream XOR block.
// Depends on ccx_pkg for register addresses; predicts results with its own cipher model.
`timescale 1ns / 100ps

module chacha20_stream_xor_tb;
    import ccx_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] result_byte
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    chacha20_stream_xor dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow key material and stream position
    logic [63:0] key_sh [4];
    logic [63:0] nonce_lo_sh;
    logic [31:0] nonce_hi_sh;
    logic [31:0] ks_word [16];
    logic [31:0] mix [16];
    logic [5:0]  byte_pos;
    logic [31:0] blk_count;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_cipher_out;

    t_cipher_out pending_out [$];
    int unsigned err_count = 0;

    // sender and receiver idle percentages, receiver hold-off
    int unsigned tx_idle_pct = 13;
    int unsigned rx_idle_pct = 70;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_ack = 0;
    int unsigned rx_hold_cycles = 0;

    function automatic logic [31:0] rot32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void mix_quarter(input int a, input int b, input int c, input int d);
        mix[a] += mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 16);
        mix[c] += mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 12);
        mix[a] += mix[b]; mix[d] = rot32(mix[d] ^ mix[a], 8);
        mix[c] += mix[d]; mix[b] = rot32(mix[b] ^ mix[c], 7);
    endfunction

    // build one 64-byte keystream block from the shadow key, counter and nonce
    function automatic void build_keystream();
        logic [31:0] seed [16];
        seed[0] = 32'h61707865; seed[1] = 32'h3320646e;
        seed[2] = 32'h79622d32; seed[3] = 32'h6b206574;
        for (int i = 0; i < 4; i++) begin
            seed[4 + 2*i] = key_sh[i][31:0];
            seed[5 + 2*i] = key_sh[i][63:32];
        end
        seed[12] = blk_count;
        seed[13] = nonce_lo_sh[31:0];
        seed[14] = nonce_lo_sh[63:32];
        seed[15] = nonce_hi_sh;
        mix = seed;
        for (int r = 0; r < 10; r++) begin
            mix_quarter(0, 4, 8, 12); mix_quarter(1, 5, 9, 13);
            mix_quarter(2, 6, 10, 14); mix_quarter(3, 7, 11, 15);
            mix_quarter(0, 5, 10, 15); mix_quarter(1, 6, 11, 12);
            mix_quarter(2, 7, 8, 13); mix_quarter(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_word[i] = mix[i] + seed[i];
    endfunction

    // advance the cipher by one byte and return the encrypted byte
    function automatic t_cipher_out cipher_byte(input logic [7:0] d, input logic l);
        t_cipher_out r;
        logic [31:0] w;
        if (byte_pos == 6'd0) begin
            build_keystream();
            blk_count = blk_count + 32'd1;
        end
        w = ks_word[byte_pos[5:2]];
        r.data = d ^ w[byte_pos[1:0]*8 +: 8];
        r.last = l;
        if (l) begin
            byte_pos = '0;
            blk_count = '0;
        end else begin
            byte_pos = byte_pos + 6'd1;
        end
        return r;
    endfunction

    // offer one byte request and wait for its acceptance
    task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                             input logic [7:0] typed_val);
        t_cipher_out r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= l;
        r = cipher_byte(d, l);
        if (typed) r.data = typed_val;
        pending_out = {pending_out, r};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the input idle until every result has come, then let the engine settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [5:0] a, input logic [63:0] v);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            RegKey0:   key_sh[0] = v;
            RegKey1:   key_sh[1] = v;
            RegKey2:   key_sh[2] = v;
            RegKey3:   key_sh[3] = v;
            RegNonceL: nonce_lo_sh = v;
            RegNonceH: nonce_hi_sh = v[31:0];
            default: ;
        endcase
    endtask

    // load all key and nonce registers; mode 0 zero, 1 all ones, else random
    task automatic load_key(input int mode);
        logic [63:0] v [6];
        for (int i = 0; i < 6; i++) begin
            v[i] = (mode == 0) ? 64'h0 : (mode == 1) ? '1 : {$urandom, $urandom};
        end
        reg_write(RegKey0, v[0]); reg_write(RegKey1, v[1]);
        reg_write(RegKey2, v[2]); reg_write(RegKey3, v[3]);
        reg_write(RegNonceL, v[4]); reg_write(RegNonceH, v[5]);
    endtask

    // random messages, mostly short, some over several blocks; may end mid-message
    task automatic random_phase(input int n_items, input bit end_open);
        int left;
        int msg_len;
        left = n_items;
        while (left > 0) begin
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(200, 64) : $urandom_range(1, 70);
            if (msg_len > left) msg_len = left;
            for (int k = 1; k <= msg_len; k++) begin
                send_byte(8'($urandom_range(255)),
                          (k == msg_len) && !(end_open && left == msg_len), 1'b0, 8'h0);
            end
            left -= msg_len;
        end
        drain();
    endtask

    // receiver: random stall, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (rx_hold_ack != rx_hold_req) begin
            rx_hold_ack <= rx_hold_req;
            rx_hold_cycles <= 200;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_cycles != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_cipher_out exp_out;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_out.size() == 0) begin
                $error("unexpected result byte %h", m_axis_tdata);
                err_count++;
            end else begin
                exp_out = pending_out.pop_front();
                if (m_axis_tdata !== exp_out.data) begin
                    $error("result_byte expected %h actual %h", exp_out.data, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== exp_out.last) begin
                    $error("result_last expected %b actual %b", exp_out.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        logic [7:0] want;
    } t_stim_row;

    // zero key and nonce give the well-known block 76 b8 e0 ad a0 ...
    t_stim_row stim_rows [] = '{
        '{8'h00, 1'b0, 1'b1, 8'h76}, '{8'hff, 1'b0, 1'b1, 8'h47},
        '{8'h00, 1'b0, 1'b1, 8'he0}, '{8'hff, 1'b0, 1'b1, 8'h52},
        '{8'h00, 1'b1, 1'b1, 8'ha0}, '{8'h00, 1'b1, 1'b1, 8'h76},
        '{8'hff, 1'b1, 1'b1, 8'h89}, '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h7f, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b0, 8'h00}, '{8'haa, 1'b1, 1'b0, 8'h00}
    };

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        for (int i = 0; i < 4; i++) key_sh[i] = '0;
        nonce_lo_sh = '0;
        nonce_hi_sh = '0;
        byte_pos = '0;
        blk_count = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows after reset, then a message over a block boundary
        foreach (stim_rows[i])
            send_byte(stim_rows[i].data, stim_rows[i].last, stim_rows[i].typed,
                      stim_rows[i].want);
        for (int k = 0; k < 70; k++) send_byte(8'h00, k == 69, 1'b0, 8'h0);
        drain();

        // all-ones key, an unmapped address, and a nonce write with upper bits set
        load_key(1);
        reg_write(6'h30, '1);
        tx_idle_pct = 13; rx_idle_pct = 70;
        random_phase(300, 1'b1);

        // new key in the middle of a message: current block keeps the old one
        load_key(2);
        random_phase(100, 1'b0);

        // block the receiver while the sender keeps offering
        load_key(2);
        tx_idle_pct = 70; rx_idle_pct = 13;
        rx_hold_req = rx_hold_req + 1;
        random_phase(400, 1'b0);

        load_key(0);
        tx_idle_pct = 0; rx_idle_pct = 0;
        random_phase(250, 1'b0);
        load_key(2);
        random_phase(250, 1'b0);

        repeat (40) @(posedge i_clk);
        if (err_count == 0 && pending_out.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
